// File: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps

package swm_pkg;

	localparam int MAX_WINDOW  = 32;
	localparam int SAMPLE_BITS = 32;
	localparam int IDX_W       = $clog2(MAX_WINDOW);
	localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
	localparam int CFG_W       = 6;
	localparam logic [LEN_W-1:0] RESET_LEN = LEN_W'(3);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [IDX_W-1:0] age_t;

	// what a cell shows to the cell below it
	typedef struct packed {
		sample_t val;
		age_t    age;
		logic    le;
	} swm_up_t;

	// compacted view a cell hands to the cell above it
	typedef struct packed {
		logic    pass;
		sample_t val;
		age_t    age;
		logic    le;
	} swm_dn_t;

	// shared controls for every cell
	typedef struct packed {
		logic load;
		logic full;
		age_t old_age;
	} swm_ctl_t;

endpackage

// File: hw/rtl/sliding_window_median.sv
`timescale 1ns / 1ps

// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tdata: sample; s_tuser: start_req
// m_*       out  m_tvalid / m_tready   m_tdata: median
// cfg_*     in   cfg_valid / cfg_ready cfg_data: window_len
//
// one item per cycle while s_tready is high; the sorted window sits in a
// row of cells that all compare, shift and insert in the cycle the item
// is accepted; the median is registered and shown the cycle after its item
// s_tready drops only while a median waits and m_tready is low
// reset empties the window and sets the window length to 3; no clearing pass

module sliding_window_median
	import swm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [SAMPLE_BITS-1:0] s_tdata,  // [31:0] sample
	input  logic [0:0]             s_tuser,  // [0] start_req
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [SAMPLE_BITS-1:0] m_tdata,  // [31:0] median
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data  // [5:0] window_len
);

	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       fill_q;
	logic                   out_valid_q;
	sample_t                out_data_q;

	logic                   accept;
	logic [LEN_W-1:0]       eff_fill;
	logic [LEN_W-1:0]       new_fill;
	logic [LEN_W-1:0]       cfg_len;
	logic [IDX_W-1:0]       mid;
	swm_ctl_t               ctl;
	sample_t                sample;
	sample_t                med;

	swm_up_t                up_w   [MAX_WINDOW+1];
	swm_dn_t                dn_w   [MAX_WINDOW+1];
	sample_t                next_w [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  held;

	assign sample    = s_tdata;
	assign s_tready  = !out_valid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;

	assign eff_fill = s_tuser[0] ? '0 : fill_q;
	assign new_fill = (eff_fill == len_q) ? len_q : eff_fill + LEN_W'(1);
	assign mid      = IDX_W'((len_q - LEN_W'(1)) >> 1);

	assign ctl.load    = accept;
	assign ctl.full    = (eff_fill == len_q);
	assign ctl.old_age = IDX_W'(len_q - LEN_W'(1));

	always_comb begin
		if (cfg_data == '0) begin
			cfg_len = LEN_W'(1);
		end else if (cfg_data > CFG_W'(MAX_WINDOW)) begin
			cfg_len = LEN_W'(MAX_WINDOW);
		end else begin
			cfg_len = LEN_W'(cfg_data);
		end
	end

	// chain boundaries
	assign dn_w[0].pass      = 1'b0;
	assign dn_w[0].val       = '0;
	assign dn_w[0].age       = '0;
	assign dn_w[0].le        = 1'b1;
	assign up_w[MAX_WINDOW]  = '0;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		assign held[i] = (eff_fill > LEN_W'(i));

		swm_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.held     (held[i]),
			.sample   (sample),
			.up_in    (up_w[i+1]),
			.dn_in    (dn_w[i]),
			.up_out   (up_w[i]),
			.dn_out   (dn_w[i+1]),
			.next_val (next_w[i])
		);
	end

	always_comb begin
		med = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (mid == IDX_W'(i)) begin
				med = med | next_w[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= RESET_LEN;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q  <= cfg_len;
				fill_q <= '0;
			end else if (accept) begin
				fill_q <= new_fill;
			end
			if (accept && new_fill == len_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && new_fill == len_q) begin
			out_data_q <= med;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_fill_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= len_q)
		else $error("fill count beyond window length");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q != '0 && len_q <= LEN_W'(MAX_WINDOW))
		else $error("window length out of range");

	a_start_no_median: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser[0] && len_q != LEN_W'(1) |=> !m_tvalid)
		else $error("median given on first item of a new run");

endmodule

// File: hw/rtl/swm_cell.sv
`timescale 1ns / 1ps

module swm_cell
	import swm_pkg::*;
(
	input  logic     clk,
	input  swm_ctl_t ctl,
	input  logic     held,
	input  sample_t  sample,
	input  swm_up_t  up_in,
	input  swm_dn_t  dn_in,
	output swm_up_t  up_out,
	output swm_dn_t  dn_out,
	output sample_t  next_val
);

	sample_t val_q;
	age_t    age_q;
	logic    le;
	logic    evict;
	age_t    next_age;

	assign le    = held && (val_q <= sample);
	assign evict = held && ctl.full && (age_q == ctl.old_age);

	assign up_out.val = val_q;
	assign up_out.age = age_q;
	assign up_out.le  = le;

	// view of the window with the evicted item squeezed out
	assign dn_out.pass = dn_in.pass | evict;
	assign dn_out.val  = dn_out.pass ? up_in.val : val_q;
	assign dn_out.age  = dn_out.pass ? up_in.age : age_q;
	assign dn_out.le   = dn_out.pass ? up_in.le  : le;

	always_comb begin
		if (dn_out.le) begin
			next_val = dn_out.val;
			next_age = dn_out.age + age_t'(1);
		end else if (dn_in.le) begin
			next_val = sample;
			next_age = '0;
		end else begin
			next_val = dn_in.val;
			next_age = dn_in.age + age_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= next_val;
			age_q <= next_age;
		end
	end

endmodule
